FILE: src/fdv_pkg.sv
`default_nettype none

package fdv_pkg;

    localparam int RANGE_W           = 16;
    localparam int TIME_W            = 32;
    localparam int MIN_W             = 16;
    localparam int SPEED_W           = 27;
    localparam int MS_PER_S          = 1000;
    // bits added by the scale to 1/16 cm per second
    localparam int MS_BITS           = 10;
    localparam int DISTANCE_BITS_DEF = 16;

    localparam logic [MIN_W-1:0] MIN_INTERVAL_RST = MIN_W'(50);

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

FILE: src/fdv_div.sv
`default_nettype none

module fdv_div #(
    parameter int NUM_W = fdv_pkg::DISTANCE_BITS_DEF + fdv_pkg::MS_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [NUM_W-1:0]          i_num,
    input  wire logic [fdv_pkg::TIME_W-1:0] i_den,
    output fdv_pkg::t_div_stat             o_stat,
    output logic      [NUM_W-1:0]          o_quot
);
    import fdv_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    // dividend bits leave at the top while quotient bits enter at the bottom
    logic [NUM_W-1:0]  r_num;
    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [TIME_W+1:0] trial;
    logic              q_bit;

    always_comb begin
        trial = {1'b0, r_rem, r_num[NUM_W-1]} - {2'b00, r_den};
        q_bit = !trial[TIME_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[NUM_W-2:0], q_bit};
                r_rem <= q_bit ? trial[TIME_W-1:0] : {r_rem[TIME_W-2:0], r_num[NUM_W-1]};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_num;

endmodule

`default_nettype wire

FILE: src/finite_difference_velocity_top.sv
`default_nettype none

// channel | dir | handshake              | word
// --------+-----+------------------------+----------------------------------------------
// s       | in  | i_s_tvalid/o_s_tready  | tdata[15:0] range, [47:16] time in ms
// m       | out | o_m_tvalid/i_m_tready  | tdata[26:0] speed, tuser[0] valid, [1] updated
// cfg     | in  | i_cfg_wen              | i_cfg_wdata[15:0] min interval in ms
//
// a word that makes a new speed has its result offered once the divider, which yields
// one quotient bit a cycle, finishes and the sequencer passes S_DIV and S_EMIT; a word
// that only stores or is ignored goes from S_EVAL straight to S_EMIT
// o_s_tready is high only while the sequencer is idle, from the cycle the result is
// offered; a finished result waits in the output register so the next word can be taken
// while the sink stalls
// reset is synchronous, active low, and clears the stored sample, speed and flags

module finite_difference_velocity_top #(
    parameter int DISTANCE_BITS = fdv_pkg::DISTANCE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // range_sixteenths, time_ms
    input  wire logic [47:0] i_s_tdata,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // speed, zero pad
    output logic      [31:0] o_m_tdata,
    // speed_valid, updated
    output logic      [1:0]  o_m_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic        i_cfg_wen,
    input  wire logic [fdv_pkg::MIN_W-1:0] i_cfg_wdata
);
    import fdv_pkg::*;

    localparam int NUM_W = DISTANCE_BITS + MS_BITS;
    // quotient compared in a width that holds both it and the speed limits
    localparam int QX_W  = ((NUM_W > SPEED_W) ? NUM_W : SPEED_W) + 1;
    localparam logic [QX_W-1:0] POS_LIM = (QX_W'(1) << (SPEED_W - 1)) - QX_W'(1);
    localparam logic [QX_W-1:0] NEG_LIM = QX_W'(1) << (SPEED_W - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_EMIT
    } t_state;

    t_state r_state;

    logic [MIN_W-1:0]         r_min_interval;
    logic [DISTANCE_BITS-1:0] r_in_range;
    logic [TIME_W-1:0]        r_in_time;
    logic [DISTANCE_BITS-1:0] r_last_range;
    logic [TIME_W-1:0]        r_last_time;
    logic [SPEED_W-1:0]       r_held_speed;
    logic                     r_have_sample;
    logic                     r_speed_ok;
    logic                     r_upd;
    logic                     r_neg;
    logic [SPEED_W-1:0]       r_out_speed;
    logic                     r_out_ok;
    logic                     r_out_upd;
    logic                     r_out_valid;

    logic [DISTANCE_BITS+RANGE_W-1:0] range_ext;
    logic [DISTANCE_BITS-1:0]         range_used;
    logic [TIME_W-1:0]                elapsed;
    logic [MIN_W-1:0]                 lim;
    logic                             long_enough;
    logic [DISTANCE_BITS:0]           diff;
    logic [DISTANCE_BITS:0]           diff_neg;
    logic [DISTANCE_BITS-1:0]         mag;
    logic [NUM_W-1:0]                 scaled;
    logic                             div_start;
    t_div_stat                        div_stat;
    logic [NUM_W-1:0]                 quot;
    logic [QX_W-1:0]                  quot_ext;
    logic [SPEED_W-1:0]               speed_q;
    logic                             in_take;
    logic                             out_free;
    logic                             emit;

    // only the low DISTANCE_BITS of the range count
    assign range_ext  = {{DISTANCE_BITS{1'b0}}, i_s_tdata[RANGE_W-1:0]};
    assign range_used = range_ext[DISTANCE_BITS-1:0];

    assign o_s_tready = (r_state == S_IDLE);
    assign in_take    = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    // result word moves into the output register
    assign emit       = (r_state == S_EMIT) && out_free;

    always_comb begin
        // wrapping timestamp difference, a zero minimum acts as one
        elapsed     = r_in_time - r_last_time;
        lim         = (r_min_interval == '0) ? MIN_W'(1) : r_min_interval;
        long_enough = elapsed >= TIME_W'(lim);
        // signed range step and its magnitude scaled to per second
        diff        = {1'b0, r_in_range} - {1'b0, r_last_range};
        diff_neg    = -diff;
        mag         = diff[DISTANCE_BITS] ? diff_neg[DISTANCE_BITS-1:0]
                                          : diff[DISTANCE_BITS-1:0];
        scaled      = NUM_W'(mag) * NUM_W'(MS_PER_S);
        div_start   = (r_state == S_EVAL) && r_have_sample && long_enough;
    end

    fdv_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (scaled),
        .i_den   (elapsed),
        .o_stat  (div_stat),
        .o_quot  (quot)
    );

    // saturate the magnitude, then apply the sign
    always_comb begin
        quot_ext = QX_W'(quot);
        if (!r_neg) begin
            speed_q = (quot_ext > POS_LIM) ? POS_LIM[SPEED_W-1:0] : quot_ext[SPEED_W-1:0];
        end else if (quot_ext > NEG_LIM) begin
            speed_q = -NEG_LIM[SPEED_W-1:0];
        end else begin
            speed_q = -quot_ext[SPEED_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_min_interval <= MIN_INTERVAL_RST;
            r_last_range   <= '0;
            r_last_time    <= '0;
            r_held_speed   <= '0;
            r_have_sample  <= 1'b0;
            r_speed_ok     <= 1'b0;
            r_upd          <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_min_interval <= i_cfg_wdata;
            end

            // load a new result word, or the sink took the pending one
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_in_range <= range_used;
                        r_in_time  <= i_s_tdata[RANGE_W +: TIME_W];
                        r_state    <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (!r_have_sample) begin
                        // first sample is only stored
                        r_last_range  <= r_in_range;
                        r_last_time   <= r_in_time;
                        r_have_sample <= 1'b1;
                        r_upd         <= 1'b0;
                        r_state       <= S_EMIT;
                    end else if (long_enough) begin
                        r_last_range <= r_in_range;
                        r_last_time  <= r_in_time;
                        r_neg        <= diff[DISTANCE_BITS];
                        r_upd        <= 1'b1;
                        r_state      <= S_DIV;
                    end else begin
                        // too soon, keep the stored sample
                        r_upd   <= 1'b0;
                        r_state <= S_EMIT;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_held_speed <= speed_q;
                        r_speed_ok   <= 1'b1;
                        r_state      <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_speed <= r_held_speed;
                        r_out_ok    <= r_speed_ok;
                        r_out_upd   <= r_upd;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(32 - SPEED_W){1'b0}}, r_out_speed};
    assign o_m_tuser  = {r_out_upd, r_out_ok};

endmodule

`default_nettype wire
